// File: rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_READ     = 8'b0000_0100,
    S_FIND     = 8'b0000_1000,
    S_UP       = 8'b0001_0000,
    S_PUT      = 8'b0010_0000,
    S_DOWN     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/core/ple_req_if.sv
interface ple_req_if import ple_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

// File: rtl/core/ple_rsp_if.sv
interface ple_rsp_if import ple_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          list_length;

  modport source (output valid, status, read_value, found_position, list_length,
                  input ready);
  modport sink (input valid, status, read_value, found_position, list_length,
                output ready);
endinterface

// File: rtl/core/positional_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit values held in one single-port-read,
// single-port-write memory with a registered read, addressed by 1-based position.
// One request is worked at a time, though a new request is taken while the previous
// result still waits on the response channel. A request is taken in idle, checked in
// dispatch, then walks memory if it needs to and waits in done until the response
// channel is free. A find scans entries from the first until a match or the end. A
// delete moves each entry after the position down by one; an insert moves each entry
// from the position up by one, or writes directly when it appends. Each entry moved
// is read and written back through the memory ports one per cycle. Length, clear and
// unused kinds return status ok with the list length. The store needs no clearing pass
// after reset: only entries below the current length are ever read.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  ple_req_if.sink  req,
  ple_rsp_if.source rsp
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_t state;

  logic [KIND_W-1:0]   req_kind;
  logic [POS_W-1:0]    req_pos;
  logic [VALUE_W-1:0]  req_value;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   cur;
  logic                issuing;
  logic                pend;
  logic [ADDR_W-1:0]   pend_idx;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [POS_W-1:0]    res_found;

  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [ADDR_W-1:0]   pos_m1;
  logic [ADDR_W-1:0]   cnt_m1;
  logic                rd_pos_ok;
  logic                ins_pos_ok;
  logic                ins_at_end;
  logic                full;
  logic                out_free;

  logic                mem_re;
  logic [ADDR_W-1:0]   mem_ra;
  logic [VALUE_W-1:0]  rd_data;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [VALUE_W-1:0]  mem_wd;

  assign pos_ext    = CMP_W'(req_pos);
  assign cnt_ext    = CMP_W'(count);
  assign pos_m1     = ADDR_W'(pos_ext - CMP_W'(1));
  assign cnt_m1     = ADDR_W'(cnt_ext - CMP_W'(1));
  assign rd_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign ins_at_end = (pos_ext == cnt_ext + CMP_W'(1));
  assign full       = (cnt_ext == CMP_W'(CAPACITY));
  assign out_free   = !rsp.valid || rsp.ready;

  assign req.ready = (state == S_IDLE);

  ple_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk (clk),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd  (rd_data),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd)
  );

  always_comb begin
    mem_re = 1'b0;
    mem_ra = cur;
    mem_we = 1'b0;
    mem_wa = pend_idx;
    mem_wd = rd_data;
    case (state)
      S_DISPATCH: begin
        if (req_kind == KIND_READ && rd_pos_ok) begin
          mem_re = 1'b1;
          mem_ra = pos_m1;
        end
      end
      S_FIND: begin
        mem_re = issuing;
      end
      S_UP: begin
        mem_re = issuing;
        mem_we = pend;
        mem_wa = pend_idx + ADDR_W'(1);
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = pos_m1;
        mem_wd = req_value;
      end
      S_DOWN: begin
        mem_re = issuing;
        mem_we = pend && (pend_idx != pos_m1);
        mem_wa = pend_idx - ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_kind  <= req.kind;
            req_pos   <= req.position;
            req_value <= req.value;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_status <= ST_OK;
          res_value  <= '0;
          res_found  <= '0;
          issuing    <= 1'b0;
          pend       <= 1'b0;
          state      <= S_DONE;
          case (req_kind)
            KIND_READ: begin
              if (rd_pos_ok) begin
                state <= S_READ;
              end else begin
                res_status <= ST_BAD_POS;
              end
            end
            KIND_FIND: begin
              if (count == '0) begin
                res_status <= ST_NOT_FOUND;
              end else begin
                cur     <= '0;
                issuing <= 1'b1;
                state   <= S_FIND;
              end
            end
            KIND_INSERT: begin
              if (!ins_pos_ok) begin
                res_status <= ST_BAD_POS;
              end else if (full) begin
                res_status <= ST_FULL;
              end else if (ins_at_end) begin
                state <= S_PUT;
              end else begin
                cur     <= cnt_m1;
                issuing <= 1'b1;
                state   <= S_UP;
              end
            end
            KIND_DELETE: begin
              if (!rd_pos_ok) begin
                res_status <= ST_BAD_POS;
              end else begin
                cur     <= pos_m1;
                issuing <= 1'b1;
                state   <= S_DOWN;
              end
            end
            KIND_CLEAR: begin
              count <= '0;
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_FIND: begin
          pend     <= issuing;
          pend_idx <= cur;
          if (issuing) begin
            if (cur == cnt_m1) begin
              issuing <= 1'b0;
            end else begin
              cur <= cur + ADDR_W'(1);
            end
          end
          if (pend) begin
            if (rd_data == req_value) begin
              res_found <= POS_W'(CMP_W'(pend_idx) + CMP_W'(1));
              issuing   <= 1'b0;
              pend      <= 1'b0;
              state     <= S_DONE;
            end else if (pend_idx == cnt_m1) begin
              res_status <= ST_NOT_FOUND;
              issuing    <= 1'b0;
              pend       <= 1'b0;
              state      <= S_DONE;
            end
          end
        end
        S_UP: begin
          pend     <= issuing;
          pend_idx <= cur;
          if (issuing) begin
            if (cur == pos_m1) begin
              issuing <= 1'b0;
            end else begin
              cur <= cur - ADDR_W'(1);
            end
          end else if (!pend) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_DOWN: begin
          pend     <= issuing;
          pend_idx <= cur;
          if (pend && (pend_idx == pos_m1)) begin
            res_value <= rd_data;
          end
          if (issuing) begin
            if (cur == cnt_m1) begin
              issuing <= 1'b0;
            end else begin
              cur <= cur + ADDR_W'(1);
            end
          end else if (!pend) begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid          <= 1'b1;
            rsp.status         <= res_status;
            rsp.read_value     <= res_value;
            rsp.found_position <= res_found;
            rsp.list_length    <= POS_W'(cnt_ext);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_mem: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mem_we && !mem_re))
    else $error("memory accessed with no transaction in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= CMP_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!mem_we && !issuing && !pend))
    else $error("memory walk still active at result");

endmodule

// File: rtl/core/ple_store.sv
module ple_store import ple_pkg::*; #(
  parameter int DEPTH  = CAPACITY_DEF,
  parameter int ADDR_W = $clog2(CAPACITY_DEF)
) (
  input  logic               clk,
  input  logic               re,
  input  logic [ADDR_W-1:0]  ra,
  output logic [VALUE_W-1:0] rd,
  input  logic               we,
  input  logic [ADDR_W-1:0]  wa,
  input  logic [VALUE_W-1:0] wd
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
